/* rtl/cmqp_pkg.sv */
// cmqp_pkg: shared types, constants and helpers for the charset map encoder.
// No dependencies; used by cmqp_store, cmqp_seq and charset_map_qp_encoder.
package cmqp_pkg;

    localparam int ENTRY_LEN_DEF = 4;
    localparam int ENTRY_COUNT   = 128;

    localparam logic [7:0] ESC_CHAR = 8'h3D;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_ADV,
        S_EMIT,
        S_NODATA
    } t_state;

    typedef struct packed {
        logic       en;
        logic [6:0] index;
        logic [1:0] pos;
        logic [7:0] data;
    } t_wr_req;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'b0, v};
        end else begin
            r = 8'h37 + {4'b0, v};
        end
        return r;
    endfunction

endpackage

/* rtl/cmqp_store.sv */
// cmqp_store: translation table memory, one byte per word, one read and one write port.
// Sweeps zeros through every word after reset. Depends on cmqp_pkg.
module cmqp_store #(
    parameter int ENTRY_LEN = cmqp_pkg::ENTRY_LEN_DEF,
    parameter int CNT_W     = $clog2(ENTRY_LEN + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cmqp_pkg::t_wr_req i_wr,
    input  logic              i_rd_en,
    input  logic [6:0]        i_rd_index,
    input  logic [CNT_W-1:0]  i_rd_pos,
    output logic [7:0]        o_rd_data,
    output logic              o_ready
);

    localparam int DEPTH  = cmqp_pkg::ENTRY_COUNT * ENTRY_LEN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [7:0]        mem [DEPTH];
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clearing;
    logic [7:0]        r_rd_data;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_ok;

    assign wr_addr = ADDR_W'(i_wr.index) * ADDR_W'(ENTRY_LEN) + ADDR_W'(i_wr.pos);
    assign rd_addr = ADDR_W'(i_rd_index) * ADDR_W'(ENTRY_LEN) + ADDR_W'(i_rd_pos);
    assign wr_ok   = i_wr.en && (32'(i_wr.pos) < 32'(ENTRY_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= 8'h00;
        end else if (wr_ok) begin
            mem[wr_addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clearing;

endmodule

/* rtl/cmqp_seq.sv */
// cmqp_seq: item control, table walk, escape expansion and output register.
// Drives the cmqp_store ports. Depends on cmqp_pkg.
module cmqp_seq #(
    parameter int ENTRY_LEN = cmqp_pkg::ENTRY_LEN_DEF,
    parameter int CNT_W     = $clog2(ENTRY_LEN + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [7:0]        i_char_code,
    input  logic              i_qp_enable,
    input  logic [6:0]        i_entry_index,
    input  logic [1:0]        i_entry_pos,
    input  logic [7:0]        i_entry_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last,
    output logic              o_no_data,
    input  logic              i_store_ready,
    output cmqp_pkg::t_wr_req o_wr,
    output logic              o_rd_en,
    output logic [6:0]        o_rd_index,
    output logic [CNT_W-1:0]  o_rd_pos,
    input  logic [7:0]        i_rd_data
);

    localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(ENTRY_LEN - 1);

    cmqp_pkg::t_state r_state, n_state;

    logic             r_table_active;
    logic [6:0]       r_char, n_char;
    logic             r_qp, n_qp;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [7:0]       r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;
    logic [1:0]       r_phase, n_phase;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;
    logic             r_out_nodata, n_out_nodata;

    logic accept;
    logic map_tbl;
    logic out_free;
    logic esc_need;
    logic emit_done;
    logic pos_end;
    logic rd_zero;

    assign accept    = i_in_valid && (r_state == cmqp_pkg::S_IDLE);
    assign map_tbl   = r_table_active && i_char_code[7];
    assign out_free  = !r_out_valid || !i_out_stall;
    assign esc_need  = r_qp && ((r_byte == cmqp_pkg::ESC_CHAR) || r_byte[7]);
    assign emit_done = (r_state == cmqp_pkg::S_EMIT) && out_free
                       && ((r_phase == 2'd2) || ((r_phase == 2'd0) && !esc_need));
    assign pos_end   = (r_pos == POS_LAST);
    assign rd_zero   = (i_rd_data == 8'h00);

    always_comb begin
        n_state = r_state;
        case (r_state)
            cmqp_pkg::S_CLEAR: begin
                if (i_store_ready) begin
                    n_state = cmqp_pkg::S_IDLE;
                end
            end
            cmqp_pkg::S_IDLE: begin
                if (accept && !i_opcode) begin
                    if (map_tbl) begin
                        n_state = cmqp_pkg::S_FETCH;
                    end else if (i_char_code != 8'h00) begin
                        n_state = cmqp_pkg::S_EMIT;
                    end else begin
                        n_state = cmqp_pkg::S_NODATA;
                    end
                end
            end
            cmqp_pkg::S_FETCH: begin
                if (r_pend_v) begin
                    n_state = cmqp_pkg::S_EMIT;
                end else if (rd_zero) begin
                    n_state = cmqp_pkg::S_NODATA;
                end else begin
                    n_state = cmqp_pkg::S_ADV;
                end
            end
            cmqp_pkg::S_ADV: begin
                n_state = pos_end ? cmqp_pkg::S_EMIT : cmqp_pkg::S_FETCH;
            end
            cmqp_pkg::S_EMIT: begin
                if (emit_done) begin
                    n_state = r_last ? cmqp_pkg::S_IDLE : cmqp_pkg::S_ADV;
                end
            end
            cmqp_pkg::S_NODATA: begin
                if (out_free) begin
                    n_state = cmqp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cmqp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_char       = r_char;
        n_qp         = r_qp;
        n_pos        = r_pos;
        n_pend       = r_pend;
        n_pend_v     = r_pend_v;
        n_byte       = r_byte;
        n_last       = r_last;
        n_phase      = r_phase;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_nodata = r_out_nodata;
        case (r_state)
            cmqp_pkg::S_IDLE: begin
                if (accept && !i_opcode) begin
                    n_char   = i_char_code[6:0];
                    n_qp     = i_qp_enable;
                    n_pos    = '0;
                    n_pend_v = 1'b0;
                    n_phase  = 2'd0;
                    n_byte   = i_char_code;
                    n_last   = 1'b1;
                end
            end
            cmqp_pkg::S_FETCH: begin
                n_phase = 2'd0;
                if (rd_zero) begin
                    n_byte = r_pend;
                    n_last = 1'b1;
                end else if (r_pend_v) begin
                    n_byte = r_pend;
                    n_last = 1'b0;
                    n_pend = i_rd_data;
                end else begin
                    n_pend   = i_rd_data;
                    n_pend_v = 1'b1;
                end
            end
            cmqp_pkg::S_ADV: begin
                if (pos_end) begin
                    n_byte  = r_pend;
                    n_last  = 1'b1;
                    n_phase = 2'd0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            cmqp_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_nodata = 1'b0;
                    case (r_phase)
                        2'd0: begin
                            if (esc_need) begin
                                n_out_byte = cmqp_pkg::ESC_CHAR;
                                n_out_last = 1'b0;
                                n_phase    = 2'd1;
                            end else begin
                                n_out_byte = r_byte;
                                n_out_last = r_last;
                            end
                        end
                        2'd1: begin
                            n_out_byte = cmqp_pkg::hex_digit(r_byte[7:4]);
                            n_out_last = 1'b0;
                            n_phase    = 2'd2;
                        end
                        default: begin
                            n_out_byte = cmqp_pkg::hex_digit(r_byte[3:0]);
                            n_out_last = r_last;
                            n_phase    = 2'd0;
                        end
                    endcase
                end
            end
            cmqp_pkg::S_NODATA: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = 8'h00;
                    n_out_last   = 1'b1;
                    n_out_nodata = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= cmqp_pkg::S_CLEAR;
            r_table_active <= 1'b0;
            r_pos          <= '0;
            r_pend_v       <= 1'b0;
            r_last         <= 1'b0;
            r_phase        <= 2'd0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_pend_v    <= n_pend_v;
            r_last      <= n_last;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_table_active <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char       <= n_char;
        r_qp         <= n_qp;
        r_pend       <= n_pend;
        r_byte       <= n_byte;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_nodata <= n_out_nodata;
    end

    assign o_in_stall = (r_state != cmqp_pkg::S_IDLE);

    assign o_wr.en    = accept && i_opcode;
    assign o_wr.index = i_entry_index;
    assign o_wr.pos   = i_entry_pos;
    assign o_wr.data  = i_entry_byte;

    assign o_rd_en    = (accept && !i_opcode && map_tbl)
                        || ((r_state == cmqp_pkg::S_ADV) && !pos_end);
    assign o_rd_index = (r_state == cmqp_pkg::S_IDLE) ? i_char_code[6:0] : r_char;
    assign o_rd_pos   = (r_state == cmqp_pkg::S_IDLE) ? '0 : CNT_W'(r_pos + 1'b1);

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;
    assign o_no_data   = r_out_nodata;

endmodule

/* rtl/charset_map_qp_encoder.sv */
// charset_map_qp_encoder: top level of the character map and quoted-printable encoder.
// Instantiates cmqp_store and cmqp_seq; depends on cmqp_pkg.
//
// Input channel (i_in_valid / o_in_stall) carries one item: a map request
// (opcode 0) or a one-byte table write (opcode 1). Output channel
// (o_out_valid / i_out_stall) carries one item per output byte, o_last on
// the final one, o_no_data on the single item of an empty mapping.
// i_cfg_we / i_cfg_wdata set table_active; write it only while idle.
// One item is worked on at a time. A passthrough byte goes from the
// EMIT state into the output register, and each output byte (plain or
// escape digit) is loaded into the output register in turn.
// A table lookup walks the entry through the single memory read port:
// a read and an advance step per stored byte plus an output step per
// produced byte, with o_in_stall high for the whole walk.
// After reset the table memory is zeroed one word a cycle, all 128*ENTRY_LEN
// words (512 at the default), with o_in_stall high; configuration writes
// are taken meanwhile. A stalled receiver holds the output register and
// the walk waits for it; the next item is taken once the last result of
// the current one is in the output register.
module charset_map_qp_encoder #(
    parameter int ENTRY_LEN = cmqp_pkg::ENTRY_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_char_code,
    input  logic       i_qp_enable,
    input  logic [6:0] i_entry_index,
    input  logic [1:0] i_entry_pos,
    input  logic [7:0] i_entry_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_no_data
);

    localparam int CNT_W = $clog2(ENTRY_LEN + 1);

    cmqp_pkg::t_wr_req wr;
    logic              rd_en;
    logic [6:0]        rd_index;
    logic [CNT_W-1:0]  rd_pos;
    logic [7:0]        rd_data;
    logic              store_ready;

    cmqp_store #(
        .ENTRY_LEN (ENTRY_LEN),
        .CNT_W     (CNT_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_rd_en    (rd_en),
        .i_rd_index (rd_index),
        .i_rd_pos   (rd_pos),
        .o_rd_data  (rd_data),
        .o_ready    (store_ready)
    );

    cmqp_seq #(
        .ENTRY_LEN (ENTRY_LEN),
        .CNT_W     (CNT_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_char_code   (i_char_code),
        .i_qp_enable   (i_qp_enable),
        .i_entry_index (i_entry_index),
        .i_entry_pos   (i_entry_pos),
        .i_entry_byte  (i_entry_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .o_no_data     (o_no_data),
        .i_store_ready (store_ready),
        .o_wr          (wr),
        .o_rd_en       (rd_en),
        .o_rd_index    (rd_index),
        .o_rd_pos      (rd_pos),
        .i_rd_data     (rd_data)
    );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for charset_map_qp_encoder: table writes and character maps,
// predicted per item by a scoreboard class and checked byte by byte on the output.
// Depends on cmqp_pkg and the charset_map_qp_encoder RTL only.
module testbench;

    localparam int ELEN          = cmqp_pkg::ENTRY_LEN_DEF;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_CAP     = 50;
    localparam logic OP_MAP      = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       no_data;
    } map_result_t;

    class map_scoreboard;
        logic [7:0]  entry_mem [cmqp_pkg::ENTRY_COUNT * ELEN];
        bit          table_active;
        map_result_t expected_q[$];
        int          mismatches;
        int          checked;

        function new();
            foreach (entry_mem[i]) entry_mem[i] = 8'h00;
            table_active = 1'b0;
            mismatches   = 0;
            checked      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] hex_char(logic [3:0] v);
            return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
        endfunction

        function void push_byte(logic [7:0] b, logic qp);
            if (qp && (b == cmqp_pkg::ESC_CHAR || b[7])) begin
                expected_q.push_back('{cmqp_pkg::ESC_CHAR, 1'b0, 1'b0});
                expected_q.push_back('{hex_char(b[7:4]), 1'b0, 1'b0});
                expected_q.push_back('{hex_char(b[3:0]), 1'b0, 1'b0});
            end else begin
                expected_q.push_back('{b, 1'b0, 1'b0});
            end
        endfunction

        function void note_item(logic op, logic [7:0] c, logic qp, logic [6:0] idx,
                                logic [1:0] pos, logic [7:0] b);
            int         first;
            int         base;
            logic [7:0] e;
            first = expected_q.size();
            if (op == OP_WRITE) begin
                if (int'(pos) < ELEN) entry_mem[int'(idx) * ELEN + int'(pos)] = b;
                return;
            end
            if (table_active && c[7]) begin
                base = int'(c[6:0]) * ELEN;
                for (int i = 0; i < ELEN; i++) begin
                    e = entry_mem[base + i];
                    if (e == 8'h00) break;
                    push_byte(e, qp);
                end
            end else if (c != 8'h00) begin
                push_byte(c, qp);
            end
            if (expected_q.size() == first) begin
                expected_q.push_back('{8'h00, 1'b1, 1'b1});
            end else begin
                expected_q[expected_q.size() - 1].last = 1'b1;
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP) $display("MISMATCH %0d: %s", mismatches, msg);
        endtask

        task check_result(logic [7:0] b, logic last, logic nd);
            map_result_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected item byte %02h last %0b no_data %0b", b, last, nd));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (!e.no_data && b !== e.out_byte)
                report($sformatf("out_byte %02h, want %02h", b, e.out_byte));
            if (last !== e.last)
                report($sformatf("last %0b, want %0b (byte %02h)", last, e.last, b));
            if (nd !== e.no_data)
                report($sformatf("no_data %0b, want %0b (byte %02h)", nd, e.no_data, b));
        endtask
    endclass

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_we      = 1'b0;
    logic       cfg_wdata   = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic       opcode      = 1'b0;
    logic [7:0] char_code   = 8'h00;
    logic       qp_enable   = 1'b0;
    logic [6:0] entry_index = 7'h00;
    logic [1:0] entry_pos   = 2'h0;
    logic [7:0] entry_byte  = 8'h00;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_no_data;

    map_scoreboard sb = new();
    int idle_pct   = 0;
    int stall_pct  = 0;
    int items_sent = 0;
    int cycles     = 0;

    charset_map_qp_encoder i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_char_code   (char_code),
        .i_qp_enable   (qp_enable),
        .i_entry_index (entry_index),
        .i_entry_pos   (entry_pos),
        .i_entry_byte  (entry_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_byte    (out_byte),
        .o_last        (out_last),
        .o_no_data     (out_no_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_byte, out_last, out_no_data);
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [7:0] c, logic qp, logic [6:0] idx,
                             logic [1:0] pos, logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        char_code   <= c;
        qp_enable   <= qp;
        entry_index <= idx;
        entry_pos   <= pos;
        entry_byte  <= b;
        do @(posedge clk); while (in_stall);
        sb.note_item(op, c, qp, idx, pos, b);
        items_sent++;
    endtask

    task automatic send_map(logic [7:0] c, logic qp);
        send_item(OP_MAP, c, qp, 7'($urandom), 2'($urandom), 8'($urandom));
    endtask

    task automatic send_write(logic [6:0] idx, logic [1:0] pos, logic [7:0] b);
        send_item(OP_WRITE, 8'($urandom), 1'($urandom), idx, pos, b);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic set_table(bit v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.table_active = v;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(4))
            0:       return 8'h00;
            1:       return cmqp_pkg::ESC_CHAR;
            2:       return 8'h80 | 8'($urandom_range(127));
            3:       return 8'($urandom_range(8'h7E, 8'h20));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic run_phase(int idle, int stall, bit active, int count);
        int         start;
        int         len;
        logic [6:0] idx;
        set_table(active);
        idle_pct  = idle;
        stall_pct = stall;
        start     = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(9) < 7) begin
                idx = 7'($urandom);
                len = $urandom_range(ELEN, 1);
                for (int p = 0; p < len; p++) send_write(idx, 2'(p), pick_byte());
                send_map({1'b1, idx}, 1'($urandom));
                if ($urandom_range(1) == 1) send_map(pick_byte(), 1'($urandom));
            end else begin
                send_item(1'($urandom), 8'($urandom), 1'($urandom), 7'($urandom),
                          2'($urandom), 8'($urandom));
            end
            if ($urandom_range(24) == 0) wait_drained();
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_table(1'b0);

        send_map(8'h00, 1'b0);
        send_map(cmqp_pkg::ESC_CHAR, 1'b1);
        send_map(cmqp_pkg::ESC_CHAR, 1'b0);
        send_map(8'h41, 1'b1);
        send_map(8'h7F, 1'b1);
        send_map(8'hFF, 1'b0);
        send_map(8'hFF, 1'b1);
        send_map(8'h80, 1'b1);
        send_write(7'h7F, 2'd0, 8'hFF);
        send_write(7'h7F, 2'd1, cmqp_pkg::ESC_CHAR);
        send_write(7'h7F, 2'd2, 8'h41);
        send_write(7'h7F, 2'd3, 8'h80);
        send_write(7'h01, 2'd0, 8'h42);
        send_write(7'h01, 2'd1, 8'h00);
        send_write(7'h01, 2'd2, 8'h43);

        set_table(1'b1);
        send_map(8'hFF, 1'b1);
        send_map(8'hFF, 1'b0);
        send_map(8'h81, 1'b1);
        send_map(8'h80, 1'b0);
        send_map(8'h00, 1'b1);
        send_map(8'h41, 1'b0);

        run_phase(0, 0, 1'b1, 80);
        run_phase(56, 0, 1'b0, 80);
        run_phase(0, 56, 1'b1, 80);
        run_phase(38, 38, 1'b1, 80);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d input items and %0d result items in %0d cycles,",
                 items_sent, sb.checked, cycles);
        $display("table on and off, escaping on and off, idle and stall mixes up to 56%%.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/cmqp_pkg.sv
rtl/cmqp_store.sv
rtl/cmqp_seq.sv
rtl/charset_map_qp_encoder.sv
tb/sv/testbench.sv
